>>> rtl/ihp_pkg.sv
// Shared types and constants for the IPv4 header parser.
`timescale 1ns / 1ps
`default_nettype none

package ihp_pkg;

    // Result field kinds
    localparam logic [4:0] KIND_VERSION   = 5'd0;
    localparam logic [4:0] KIND_IHL       = 5'd1;
    localparam logic [4:0] KIND_DSCP      = 5'd2;
    localparam logic [4:0] KIND_ECN       = 5'd3;
    localparam logic [4:0] KIND_TOTLEN    = 5'd4;
    localparam logic [4:0] KIND_ID        = 5'd5;
    localparam logic [4:0] KIND_DF        = 5'd6;
    localparam logic [4:0] KIND_MF        = 5'd7;
    localparam logic [4:0] KIND_FRAGOFF   = 5'd8;
    localparam logic [4:0] KIND_TTL       = 5'd9;
    localparam logic [4:0] KIND_PROTO     = 5'd10;
    localparam logic [4:0] KIND_CSUM      = 5'd11;
    localparam logic [4:0] KIND_SRC       = 5'd12;
    localparam logic [4:0] KIND_DST       = 5'd13;
    localparam logic [4:0] KIND_OPTION    = 5'd14;
    localparam logic [4:0] KIND_OPTLEN    = 5'd15;
    localparam logic [4:0] KIND_OPTDATA   = 5'd16;
    localparam logic [4:0] KIND_PAYLOAD   = 5'd17;
    localparam logic [4:0] KIND_BADIHL    = 5'd18;
    localparam logic [4:0] KIND_BADOPTLEN = 5'd19;

    localparam logic [4:0] OPT_NUM_EOL = 5'd0;
    localparam logic [4:0] OPT_NUM_NOP = 5'd1;

    localparam logic [3:0] MIN_IHL     = 4'd5;
    localparam logic [15:0] HDR_FIXED_END = 16'd20;

    // Results per input byte, and run queue depth
    localparam int MAX_RES   = 3;
    localparam int RUN_DEPTH = 4;
    localparam int RUN_PTR_W = 2;

    typedef enum logic [1:0] {
        OPT_TYPE,
        OPT_LEN,
        OPT_DATA,
        OPT_SKIP
    } opt_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [31:0] field_value;
        logic        option_copied;
        logic [1:0]  option_class;
        logic        last_of_run;
        logic        end_of_frame;
    } result_t;

    // All results caused by one byte
    typedef struct packed {
        logic [1:0]             count;
        result_t [MAX_RES-1:0]  res;
    } run_t;

endpackage

`default_nettype wire

>>> rtl/ihp_front.sv
// Byte parser: tracks header position and builds the result run for each byte.
`timescale 1ns / 1ps
`default_nettype none

module ihp_front
    import ihp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  accept,
    output logic       run_push,
    output run_t       run_data
);

    logic [15:0] pos_reg, pos_next;
    logic        inframe_reg, inframe_next;
    logic [3:0]  hw_reg, hw_next;
    logic [15:0] flen_reg, flen_next;
    logic [31:0] acc_reg, acc_next;
    opt_phase_t  phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;

    logic        start;
    logic        active;
    logic [7:0]  b;
    logic [15:0] eff_pos;
    logic [3:0]  eff_hw;
    logic [15:0] eff_flen;
    logic [31:0] eff_acc;
    opt_phase_t  eff_phase;
    logic [7:0]  eff_left;
    logic [31:0] acc;
    logic [15:0] hdr;
    logic [15:0] span;
    logic [1:0]  n;
    logic        final_byte;
    logic [7:0]  left_dec;
    result_t [MAX_RES-1:0] res;

    assign b      = item.data_byte;
    assign start  = item.frame_start;
    assign active = start | inframe_reg;

    // A start byte sees freshly cleared state
    assign eff_pos   = start ? '0 : pos_reg;
    assign eff_hw    = start ? '0 : hw_reg;
    assign eff_flen  = start ? '0 : flen_reg;
    assign eff_acc   = start ? '0 : acc_reg;
    assign eff_phase = start ? OPT_TYPE : phase_reg;
    assign eff_left  = start ? '0 : left_reg;

    assign acc      = {eff_acc[23:0], b};
    assign hdr      = {10'd0, eff_hw, 2'b00};
    assign span     = (eff_flen > hdr) ? eff_flen : hdr;
    assign left_dec = eff_left - 8'd1;

    always_comb
    begin
        res        = '0;
        n          = 2'd0;
        final_byte = 1'b0;
        hw_next    = eff_hw;
        flen_next  = eff_flen;
        phase_next = eff_phase;
        left_next  = eff_left;

        unique case (eff_pos)
            16'd0:
            begin
                hw_next = b[3:0];
                res[0].field_kind  = KIND_VERSION;
                res[0].field_value = {28'd0, b[7:4]};
                res[1].field_kind  = KIND_IHL;
                res[1].field_value = {28'd0, b[3:0]};
                n = 2'd2;
                if (b[3:0] < MIN_IHL)
                begin
                    res[2].field_kind  = KIND_BADIHL;
                    res[2].field_value = {28'd0, b[3:0]};
                    n          = 2'd3;
                    final_byte = 1'b1;
                end
            end
            16'd1:
            begin
                res[0].field_kind  = KIND_DSCP;
                res[0].field_value = {26'd0, b[7:2]};
                res[1].field_kind  = KIND_ECN;
                res[1].field_value = {30'd0, b[1:0]};
                n = 2'd2;
            end
            16'd3:
            begin
                flen_next = acc[15:0];
                res[0].field_kind  = KIND_TOTLEN;
                res[0].field_value = {16'd0, acc[15:0]};
                n = 2'd1;
            end
            16'd5:
            begin
                res[0].field_kind  = KIND_ID;
                res[0].field_value = {16'd0, acc[15:0]};
                n = 2'd1;
            end
            16'd6:
            begin
                res[0].field_kind  = KIND_DF;
                res[0].field_value = {31'd0, b[6]};
                res[1].field_kind  = KIND_MF;
                res[1].field_value = {31'd0, b[5]};
                n = 2'd2;
            end
            16'd7:
            begin
                res[0].field_kind  = KIND_FRAGOFF;
                res[0].field_value = {19'd0, acc[12:0]};
                n = 2'd1;
            end
            16'd8:
            begin
                res[0].field_kind  = KIND_TTL;
                res[0].field_value = {24'd0, b};
                n = 2'd1;
            end
            16'd9:
            begin
                res[0].field_kind  = KIND_PROTO;
                res[0].field_value = {24'd0, b};
                n = 2'd1;
            end
            16'd11:
            begin
                res[0].field_kind  = KIND_CSUM;
                res[0].field_value = {16'd0, acc[15:0]};
                n = 2'd1;
            end
            16'd15:
            begin
                res[0].field_kind  = KIND_SRC;
                res[0].field_value = acc;
                n = 2'd1;
            end
            16'd19:
            begin
                res[0].field_kind  = KIND_DST;
                res[0].field_value = acc;
                n = 2'd1;
            end
            default:
            begin
                if (eff_pos >= HDR_FIXED_END && eff_pos < hdr)
                begin
                    case (eff_phase)
                        OPT_TYPE:
                        begin
                            res[0].field_kind    = KIND_OPTION;
                            res[0].field_value   = {27'd0, b[4:0]};
                            res[0].option_copied = b[7];
                            res[0].option_class  = b[6:5];
                            n = 2'd1;
                            if (b[4:0] == OPT_NUM_EOL)
                                phase_next = OPT_SKIP;
                            else if (b[4:0] != OPT_NUM_NOP)
                                phase_next = OPT_LEN;
                        end
                        OPT_LEN:
                        begin
                            n = 2'd1;
                            if (b < 8'd2)
                            begin
                                res[0].field_kind  = KIND_BADOPTLEN;
                                res[0].field_value = {24'd0, b};
                                phase_next = OPT_SKIP;
                            end
                            else
                            begin
                                res[0].field_kind  = KIND_OPTLEN;
                                res[0].field_value = {24'd0, b - 8'd2};
                                if (b == 8'd2)
                                    phase_next = OPT_TYPE;
                                else
                                begin
                                    left_next  = b - 8'd2;
                                    phase_next = OPT_DATA;
                                end
                            end
                        end
                        OPT_DATA:
                        begin
                            res[0].field_kind  = KIND_OPTDATA;
                            res[0].field_value = {24'd0, b};
                            n = 2'd1;
                            left_next = left_dec;
                            if (left_dec == 8'd0)
                                phase_next = OPT_TYPE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (eff_pos >= hdr && eff_pos < eff_flen)
                begin
                    res[0].field_kind  = KIND_PAYLOAD;
                    res[0].field_value = {24'd0, b};
                    n = 2'd1;
                end
            end
        endcase

        if (eff_pos >= 16'd19 && ({1'b0, eff_pos} + 17'd1) >= {1'b0, span})
            final_byte = 1'b1;

        for (int i = 0; i < MAX_RES; i++)
        begin
            if (n == 2'(i + 1))
            begin
                res[i].last_of_run  = 1'b1;
                res[i].end_of_frame = final_byte;
            end
        end
    end

    assign acc_next     = acc;
    assign inframe_next = ~final_byte;
    assign pos_next     = final_byte ? eff_pos : eff_pos + 16'd1;

    assign run_push       = accept & active & (n != 2'd0);
    assign run_data.count = n;
    assign run_data.res   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            inframe_reg <= 1'b0;
            hw_reg      <= '0;
            flen_reg    <= '0;
            acc_reg     <= '0;
            phase_reg   <= OPT_TYPE;
            left_reg    <= '0;
        end
        else if (accept && active)
        begin
            pos_reg     <= pos_next;
            inframe_reg <= inframe_next;
            hw_reg      <= hw_next;
            flen_reg    <= flen_next;
            acc_reg     <= acc_next;
            phase_reg   <= phase_next;
            left_reg    <= left_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ihp_run_fifo.sv
// Short queue of result runs between the parser and the result emitter.
`timescale 1ns / 1ps
`default_nettype none

module ihp_run_fifo
    import ihp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire run_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output run_t      rd_data,
    output logic      empty
);

    run_t                 mem [RUN_DEPTH];
    logic [RUN_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RUN_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RUN_PTR_W:0]   cnt_reg, cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (cnt_reg == (RUN_PTR_W+1)'(RUN_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem[rd_ptr_reg];

    assign wr_ptr_next = do_wr ? wr_ptr_reg + RUN_PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? rd_ptr_reg + RUN_PTR_W'(1) : rd_ptr_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + (RUN_PTR_W+1)'(1);
        else if (!do_wr && do_rd)
            cnt_next = cnt_reg - (RUN_PTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ihp_emitter.sv
// Result emitter: walks the results of the oldest queued run, one per request.
`timescale 1ns / 1ps
`default_nettype none

module ihp_emitter
    import ihp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire run_t    head,
    input  wire logic    head_empty,
    output logic         head_pop,
    output result_t      result,
    output logic         empty,
    input  wire logic    pop
);

    logic [1:0] idx_reg, idx_next;
    logic       take;
    logic       run_done;

    assign empty    = head_empty;
    assign result   = head.res[idx_reg];
    assign take     = pop & ~head_empty;
    assign run_done = (idx_reg == head.count - 2'd1);
    assign head_pop = take & run_done;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = run_done ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

>>> rtl/ipv4_header_parser_top.sv
// A taken byte's run is written into the run queue; results come from the oldest run.
// Throughput: one byte per cycle while the four-run queue has room; results leave
// one per cycle while pop is held, and a byte's run stays at the queue head until its last result.
// Reset: rst_n clears parser position, frame state and queue pointers asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_parser_top
    import ihp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire logic    push,
    output logic         full,
    output result_t      result,
    output logic         empty,
    input  wire logic    pop
);

    logic run_push;
    run_t run_wr;
    run_t run_head;
    logic run_full;
    logic run_empty;
    logic run_pop;
    logic accept;

    assign full   = run_full;
    assign accept = push & ~run_full;

    ihp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .accept   (accept),
        .run_push (run_push),
        .run_data (run_wr)
    );

    ihp_run_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (run_push),
        .wr_data (run_wr),
        .full    (run_full),
        .rd_en   (run_pop),
        .rd_data (run_head),
        .empty   (run_empty)
    );

    ihp_emitter u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (run_head),
        .head_empty (run_empty),
        .head_pop   (run_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTH
    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.end_of_frame) |-> result.last_of_run)
        else $error("end_of_frame on a result that is not last of its run");

    a_opt_bits_only_on_option: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.option_copied || result.option_class != 2'd0))
            |-> result.field_kind == KIND_OPTION)
        else $error("option type bits set on a non-option result");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.field_kind <= KIND_BADOPTLEN)
        else $error("result kind out of range");

    a_run_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        run_pop |-> result.last_of_run)
        else $error("run retired before its last result");
`endif

endmodule

`default_nettype wire

>>> tb/ipv4_field_checker.sv
// Scoreboard for the IPv4 header parser: predicts the tagged fields and checks each result.
`timescale 1ns / 1ps

module ipv4_field_checker
    import ihp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item,
    input  wire logic    push,
    input  wire logic    full,
    input  wire result_t result,
    input  wire logic    empty,
    input  wire logic    pop,
    output int           errors,
    output int           pending
);

    // Parser state as seen from outside
    logic [15:0] byte_pos  = '0;
    logic        in_frame  = 1'b0;
    logic [3:0]  hdr_words = '0;
    logic [15:0] frame_len = '0;
    logic [31:0] accum     = '0;
    opt_phase_t  opt_phase = OPT_TYPE;
    logic [7:0]  opt_left  = '0;

    result_t expected_fields[$];
    int      mismatches = 0;
    int      depth      = 0;

    assign errors  = mismatches;
    assign pending = depth;

    function automatic result_t plain_field(input logic [4:0] kind, input logic [31:0] value);
        result_t r;
        r = '0;
        r.field_kind  = kind;
        r.field_value = value;
        return r;
    endfunction

    // Work out the fields that one packet byte produces and queue them.
    task automatic decode_byte(input item_t it);
        logic [7:0]  b;
        logic [15:0] pos;
        int          hdr_bytes;
        int          span;
        logic [4:0]  num;
        logic        done;
        result_t     r;
        result_t     run[$];
        b    = it.data_byte;
        done = 1'b0;
        if (it.frame_start) begin
            byte_pos  = '0;
            hdr_words = '0;
            frame_len = '0;
            accum     = '0;
            opt_phase = OPT_TYPE;
            opt_left  = '0;
            in_frame  = 1'b1;
        end else if (!in_frame) begin
            return;
        end
        pos       = byte_pos;
        accum     = {accum[23:0], b};
        hdr_bytes = int'(hdr_words) * 4;

        // byte offsets within the fixed 20-byte header
        case (pos)
            16'd0: begin
                hdr_words = b[3:0];
                run.push_back(plain_field(KIND_VERSION, b[7:4]));
                run.push_back(plain_field(KIND_IHL, b[3:0]));
                if (b[3:0] < MIN_IHL) begin
                    run.push_back(plain_field(KIND_BADIHL, b[3:0]));
                    done = 1'b1;
                end
            end
            16'd1: begin
                run.push_back(plain_field(KIND_DSCP, b[7:2]));
                run.push_back(plain_field(KIND_ECN, b[1:0]));
            end
            16'd3: begin
                frame_len = accum[15:0];
                run.push_back(plain_field(KIND_TOTLEN, accum[15:0]));
            end
            16'd5: run.push_back(plain_field(KIND_ID, accum[15:0]));
            16'd6: begin
                run.push_back(plain_field(KIND_DF, b[6]));
                run.push_back(plain_field(KIND_MF, b[5]));
            end
            16'd7:  run.push_back(plain_field(KIND_FRAGOFF, accum[12:0]));
            16'd8:  run.push_back(plain_field(KIND_TTL, b));
            16'd9:  run.push_back(plain_field(KIND_PROTO, b));
            16'd11: run.push_back(plain_field(KIND_CSUM, accum[15:0]));
            16'd15: run.push_back(plain_field(KIND_SRC, accum));
            16'd19: run.push_back(plain_field(KIND_DST, accum));
            default: begin
                if (pos >= HDR_FIXED_END && int'(pos) < hdr_bytes) begin
                    case (opt_phase)
                        OPT_TYPE: begin
                            num = b[4:0];
                            r = plain_field(KIND_OPTION, num);
                            r.option_copied = b[7];
                            r.option_class  = b[6:5];
                            run.push_back(r);
                            if (num == OPT_NUM_EOL)
                                opt_phase = OPT_SKIP;
                            else if (num != OPT_NUM_NOP)
                                opt_phase = OPT_LEN;
                        end
                        OPT_LEN: begin
                            // length byte counts type and length bytes too
                            if (b < 8'd2) begin
                                run.push_back(plain_field(KIND_BADOPTLEN, b));
                                opt_phase = OPT_SKIP;
                            end else begin
                                run.push_back(plain_field(KIND_OPTLEN, b - 8'd2));
                                if (b == 8'd2) begin
                                    opt_phase = OPT_TYPE;
                                end else begin
                                    opt_left  = b - 8'd2;
                                    opt_phase = OPT_DATA;
                                end
                            end
                        end
                        OPT_DATA: begin
                            run.push_back(plain_field(KIND_OPTDATA, b));
                            opt_left = opt_left - 8'd1;
                            if (opt_left == 8'd0)
                                opt_phase = OPT_TYPE;
                        end
                        default: ;
                    endcase
                end else if (int'(pos) >= hdr_bytes && pos < frame_len) begin
                    run.push_back(plain_field(KIND_PAYLOAD, b));
                end
            end
        endcase

        if (pos >= HDR_FIXED_END - 16'd1) begin
            span = (int'(frame_len) > hdr_bytes) ? int'(frame_len) : hdr_bytes;
            if (int'(pos) + 1 >= span)
                done = 1'b1;
        end

        if (run.size() > 0) begin
            run[run.size() - 1].last_of_run  = 1'b1;
            run[run.size() - 1].end_of_frame = done;
        end
        foreach (run[i])
            expected_fields.push_back(run[i]);

        if (done)
            in_frame = 1'b0;
        else
            byte_pos = byte_pos + 16'd1;
    endtask

    always @(posedge clk) begin : watch
        result_t want;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_fields.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result kind=%0d value=%h", $time,
                             result.field_kind, result.field_value);
                end else begin
                    want = expected_fields.pop_front();
                    if (result !== want) begin
                        mismatches++;
                        $display("%0t: expected kind=%0d value=%h copied=%b class=%0d last=%b eof=%b",
                                 $time, want.field_kind, want.field_value, want.option_copied,
                                 want.option_class, want.last_of_run, want.end_of_frame);
                        $display("%0t: actual   kind=%0d value=%h copied=%b class=%0d last=%b eof=%b",
                                 $time, result.field_kind, result.field_value,
                                 result.option_copied, result.option_class,
                                 result.last_of_run, result.end_of_frame);
                    end
                end
            end
            if (push && !full)
                decode_byte(item);
            depth = expected_fields.size();
        end
    end

endmodule

>>> tb/ipv4_header_parser_top_test.sv
// Testbench top for the IPv4 header parser: byte stimulus, result popping and verdict.
`timescale 1ns / 1ps

module ipv4_header_parser_top_test;
    import ihp_pkg::*;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    item_t   item  = '0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    logic    full;
    logic    empty;
    result_t result;

    int   fail_count;
    int   pending_fields;
    int   bytes_sent = 0;
    logic eager      = 1'b0;

    ipv4_header_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    ipv4_field_checker field_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .errors  (fail_count),
        .pending (pending_fields)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after a rising edge that leaves full low.
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = 0;
        if (!eager && $urandom_range(0, 99) < 20)
            gap = idle_span();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= '{data_byte: b, frame_start: s};
        push <= 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending_fields != 0)
            @(negedge clk);
    endtask

    task automatic emit_packet();
        logic [7:0] pkt[$];
        logic [3:0] ver;
        logic [4:0] num;
        int         ihl, hdr, tot, span, cut, room, olen, k;
        ver = ($urandom_range(0, 99) < 80) ? 4'd4 : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 8)
        begin
            // header length too small: one byte, then bytes that get dropped
            send_byte({ver, 4'($urandom_range(0, 4))}, 1'b1);
            bytes_sent++;
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
            return;
        end
        k = $urandom_range(0, 99);
        if (k < 60)
            ihl = $urandom_range(6, 8);
        else if (k < 85)
            ihl = 5;
        else
            ihl = $urandom_range(9, 15);
        hdr = ihl * 4;

        k = $urandom_range(0, 99);
        if (k < 15)
            tot = $urandom_range(0, hdr);
        else if (k < 92)
            tot = hdr + $urandom_range(1, 12);
        else
            tot = $urandom_range(hdr + 13, 65535);
        span = (tot > hdr) ? tot : hdr;
        cut  = span;
        // huge packets are always cut short by a new start
        if (tot > hdr + 12)
            cut = hdr + $urandom_range(0, 10);
        else if ($urandom_range(0, 99) < 6)
            cut = $urandom_range(1, span - 1);

        pkt.push_back({ver, 4'(ihl)});
        pkt.push_back(8'($urandom));
        pkt.push_back(8'(tot >> 8));
        pkt.push_back(8'(tot));
        repeat (16) pkt.push_back(8'($urandom));

        while (pkt.size() < hdr)
        begin
            k = $urandom_range(0, 99);
            if (k < 10)
            begin
                pkt.push_back({3'($urandom_range(0, 7)), OPT_NUM_EOL});
                while (pkt.size() < hdr)
                    pkt.push_back(8'($urandom));
            end
            else if (k < 30)
            begin
                pkt.push_back({3'($urandom_range(0, 7)), OPT_NUM_NOP});
            end
            else
            begin
                num = 5'($urandom_range(2, 31));
                pkt.push_back({3'($urandom_range(0, 7)), num});
                room = hdr - pkt.size();
                if (k < 38)
                    olen = $urandom_range(0, 1);
                else if (k < 45 || room < 1)
                    olen = $urandom_range(2, 255);
                else
                    olen = $urandom_range(2, room + 1);
                pkt.push_back(8'(olen));
                if (olen > 2)
                    repeat (olen - 2) pkt.push_back(8'($urandom));
            end
        end
        while (pkt.size() > hdr)
            pkt.pop_back();
        while (pkt.size() < cut)
            pkt.push_back(8'($urandom));
        while (pkt.size() > cut)
            pkt.pop_back();

        foreach (pkt[i])
            send_byte(pkt[i], i == 0);
        bytes_sent += pkt.size();

        // stray bytes after a finished packet are ignored
        if (cut == span && $urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    // result side: random stalls, with stretches of steady popping
    initial
    begin : pop_side
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        forever
        begin
            @(negedge clk);
            if (calm_left > 0)
            begin
                calm_left--;
                pop <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(50, 150);
                else if (r < 30)
                    stall_left = idle_span();
            end
        end
    end

    initial
    begin : stimulus
        logic drained;
        drained = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes outside any packet, bad header lengths, then an all-extreme header
        send_byte(8'hFF, 1'b0);
        send_byte(8'h40, 1'b1);
        send_byte(8'hF4, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h45, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        repeat (12) send_byte(8'hFF, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        bytes_sent = 22;
        hold_until_drained();

        while (bytes_sent < 330)
        begin
            eager = ($urandom_range(0, 3) == 0);
            emit_packet();
            if (!drained && bytes_sent > 165)
            begin
                hold_until_drained();
                drained = 1'b1;
            end
        end

        push <= 1'b0;
        @(negedge clk);
        while (pending_fields != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/ihp_pkg.sv
rtl/ihp_front.sv
rtl/ihp_run_fifo.sv
rtl/ihp_emitter.sv
rtl/ipv4_header_parser_top.sv
tb/ipv4_field_checker.sv
tb/ipv4_header_parser_top_test.sv
